FILE: rtl/mart_pkg.sv
package mart_pkg;

  localparam int ADDR_W = 39;
  localparam int LEN_W  = 39;
  localparam int END_W  = 40;
  localparam int FLAG_W = 8;
  localparam int OFFS_W = 32;
  localparam int SIZE_W = 32;

  // input item tdata width, whole bytes
  localparam int IN_DW = 152;

  // area fields carried on result tdata after the entry index
  localparam int AREA_W = ADDR_W + END_W + FLAG_W + OFFS_W + SIZE_W;

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_LOOKUP = 1'b1;

  localparam logic [FLAG_W-1:0] VALID_FLAG = 8'h01;

  typedef struct packed {
    logic [SIZE_W-1:0] fsize;
    logic [OFFS_W-1:0] offset;
    logic [FLAG_W-1:0] flags;
    logic [END_W-1:0]  end_addr;
    logic [ADDR_W-1:0] start_addr;
  } area_t;

  typedef struct packed {
    logic valid;
    logic hit;
  } tok_ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_HOLD
  } state_t;

endpackage

FILE: rtl/mart_cell.sv
module mart_cell #(
  parameter int IDX_W = 4,
  parameter int CNT_W = 5,
  parameter int IDX   = 0
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       wr_en,
  input  logic [IDX_W-1:0]           wr_ptr,
  input  mart_pkg::area_t            wr_area,
  input  logic [CNT_W-1:0]           count,
  input  mart_pkg::tok_ctl_t         in_ctl,
  input  logic [mart_pkg::ADDR_W-1:0] in_addr,
  input  logic [IDX_W-1:0]           in_idx,
  input  mart_pkg::area_t            in_area,
  output mart_pkg::tok_ctl_t         out_ctl,
  output logic [mart_pkg::ADDR_W-1:0] out_addr,
  output logic [IDX_W-1:0]           out_idx,
  output mart_pkg::area_t            out_area
);

  mart_pkg::area_t                area_r;
  mart_pkg::tok_ctl_t             ctl_r;
  mart_pkg::tok_ctl_t             ctl_nxt;
  logic [mart_pkg::ADDR_W-1:0]    addr_r;
  logic [IDX_W-1:0]               idx_r;
  logic [IDX_W-1:0]               idx_nxt;
  mart_pkg::area_t                tarea_r;
  mart_pkg::area_t                tarea_nxt;
  logic                           match;

  // entry storage
  always_ff @(posedge clk) begin
    if (wr_en && (wr_ptr == IDX_W'(IDX))) begin
      area_r <= wr_area;
    end
  end

  assign match = in_ctl.valid && !in_ctl.hit && (CNT_W'(IDX) < count) &&
                 (in_addr >= area_r.start_addr) &&
                 ({1'b0, in_addr} < area_r.end_addr);

  always_comb begin
    ctl_nxt.valid = in_ctl.valid;
    ctl_nxt.hit   = in_ctl.hit | match;
    idx_nxt       = match ? IDX_W'(IDX) : in_idx;
    tarea_nxt     = match ? area_r : in_area;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r  <= in_addr;
    idx_r   <= idx_nxt;
    tarea_r <= tarea_nxt;
  end

  assign out_ctl  = ctl_r;
  assign out_addr = addr_r;
  assign out_idx  = idx_r;
  assign out_area = tarea_r;

endmodule

FILE: rtl/memory_area_range_table.sv
// Table of memory areas held in insertion order, one area per cell of a chain.
// An insert appends [addr, addr+length) with its flags (valid bit forced on),
// file offset and file size, and answers with the slot written, or with
// full_res when all MAX_AREAS slots are taken. A lookup is sent down the
// chain one cell per cycle; the first cell whose area holds the address
// claims it, so the earliest inserted match wins. An insert's result goes to the
// pending result register and from there to the output register; a lookup's
// result first passes every cell of the chain. One item is in progress at a time;
// the next is accepted as soon as the previous result has moved to the output
// register, even while that result still waits to be taken.
module memory_area_range_table #(
  parameter int MAX_AREAS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  // addr, length, area_flags, content_offset, content_size
  input  logic [mart_pkg::IN_DW-1:0]   in_tdata,
  // action
  input  logic                         in_tuser,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  // entry_index, area_start, area_end, area_flags_out, offset_out, size_out
  output logic [((((MAX_AREAS > 1) ? $clog2(MAX_AREAS) : 1) +
                  mart_pkg::AREA_W + 7) / 8) * 8 - 1:0] out_tdata,
  // found, full_res
  output logic [1:0]                   out_tuser
);

  localparam int IDX_W  = (MAX_AREAS > 1) ? $clog2(MAX_AREAS) : 1;
  localparam int CNT_W  = $clog2(MAX_AREAS + 1);
  localparam int OUT_DW = ((IDX_W + mart_pkg::AREA_W + 7) / 8) * 8;

  mart_pkg::state_t               state_r;
  mart_pkg::state_t               state_nxt;
  logic [CNT_W-1:0]               count_r;
  logic                           accept;
  logic                           ins_go;
  logic                           look_go;
  logic                           res_walk;
  logic                           out_load;
  logic                           full;
  logic                           wr_en;

  logic                           in_action;
  logic [mart_pkg::ADDR_W-1:0]    in_addr;
  logic [mart_pkg::LEN_W-1:0]     in_len;
  mart_pkg::area_t                new_area;

  logic                           res_found_r;
  logic                           res_full_r;
  logic [IDX_W-1:0]               res_idx_r;
  mart_pkg::area_t                res_area_r;

  logic                           out_valid_r;
  logic                           out_found_r;
  logic                           out_full_r;
  logic [IDX_W-1:0]               out_idx_r;
  mart_pkg::area_t                out_area_r;

  mart_pkg::tok_ctl_t             ctl_chain  [0:MAX_AREAS];
  logic [mart_pkg::ADDR_W-1:0]    addr_chain [0:MAX_AREAS];
  logic [IDX_W-1:0]               idx_chain  [0:MAX_AREAS];
  mart_pkg::area_t                area_chain [0:MAX_AREAS];

  // input unpacking
  assign in_action           = in_tuser;
  assign in_addr             = in_tdata[38:0];
  assign in_len              = in_tdata[77:39];
  assign new_area.start_addr = in_addr;
  assign new_area.end_addr   = {1'b0, in_addr} + {1'b0, in_len};
  assign new_area.flags      = in_tdata[85:78] | mart_pkg::VALID_FLAG;
  assign new_area.offset     = in_tdata[117:86];
  assign new_area.fsize      = in_tdata[149:118];

  assign full   = (count_r == CNT_W'(MAX_AREAS));
  assign accept = in_tvalid && in_tready;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mart_pkg::ST_IDLE: begin
        if (accept) begin
          state_nxt = (in_action == mart_pkg::ACT_LOOKUP) ? mart_pkg::ST_WALK
                                                          : mart_pkg::ST_HOLD;
        end
      end
      mart_pkg::ST_WALK: begin
        if (ctl_chain[MAX_AREAS].valid) begin
          state_nxt = mart_pkg::ST_HOLD;
        end
      end
      mart_pkg::ST_HOLD: begin
        if (!out_valid_r || out_tready) begin
          state_nxt = mart_pkg::ST_IDLE;
        end
      end
      default: state_nxt = mart_pkg::ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_tready = 1'b0;
    res_walk  = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      mart_pkg::ST_IDLE: in_tready = 1'b1;
      mart_pkg::ST_WALK: res_walk  = ctl_chain[MAX_AREAS].valid;
      mart_pkg::ST_HOLD: out_load  = !out_valid_r || out_tready;
      default: in_tready = 1'b0;
    endcase
  end

  assign ins_go  = accept && (in_action == mart_pkg::ACT_INSERT);
  assign look_go = accept && (in_action == mart_pkg::ACT_LOOKUP);
  assign wr_en   = ins_go && !full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mart_pkg::ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (wr_en) begin
        count_r <= count_r + 1'b1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // pending result
  always_ff @(posedge clk) begin
    if (ins_go) begin
      res_found_r <= !full;
      res_full_r  <= full;
      res_idx_r   <= full ? '0 : count_r[IDX_W-1:0];
      res_area_r  <= full ? '0 : new_area;
    end else if (res_walk) begin
      res_found_r <= ctl_chain[MAX_AREAS].hit;
      res_full_r  <= 1'b0;
      res_idx_r   <= idx_chain[MAX_AREAS];
      res_area_r  <= area_chain[MAX_AREAS];
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_found_r <= res_found_r;
      out_full_r  <= res_full_r;
      out_idx_r   <= res_idx_r;
      out_area_r  <= res_area_r;
    end
  end

  // chain head
  assign ctl_chain[0].valid = look_go;
  assign ctl_chain[0].hit   = 1'b0;
  assign addr_chain[0]      = in_addr;
  assign idx_chain[0]       = '0;
  assign area_chain[0]      = '0;

  for (genvar g = 0; g < MAX_AREAS; g++) begin : g_cell
    mart_cell #(
      .IDX_W (IDX_W),
      .CNT_W (CNT_W),
      .IDX   (g)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .wr_en    (wr_en),
      .wr_ptr   (count_r[IDX_W-1:0]),
      .wr_area  (new_area),
      .count    (count_r),
      .in_ctl   (ctl_chain[g]),
      .in_addr  (addr_chain[g]),
      .in_idx   (idx_chain[g]),
      .in_area  (area_chain[g]),
      .out_ctl  (ctl_chain[g+1]),
      .out_addr (addr_chain[g+1]),
      .out_idx  (idx_chain[g+1]),
      .out_area (area_chain[g+1])
    );
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = {out_full_r, out_found_r};
  assign out_tdata  = OUT_DW'({out_area_r, out_idx_r});

  // assertions
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_AREAS))
    else $error("area count beyond table size");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (ins_go && !full) |=> (count_r == CNT_W'($past(count_r) + 1'b1)))
    else $error("insert did not advance area count");

  a_tail_walk: assert property (@(posedge clk) disable iff (!rst_n)
    ctl_chain[MAX_AREAS].valid |-> (state_r == mart_pkg::ST_WALK))
    else $error("lookup left the chain outside a walk");

  a_res_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tuser[0] && out_tuser[1]))
    else $error("result both found and full");

endmodule

FILE: dv/memory_area_range_table_tb.sv
`timescale 1ns / 100ps

module memory_area_range_table_tb;

  localparam int MAX_AREAS = 16;
  localparam int IDX_W = 4;
  localparam int OUT_DW = ((IDX_W + mart_pkg::AREA_W + 7) / 8) * 8;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 2 * MAX_AREAS + 8;
  localparam int PHASE_ITEMS = 270;

  typedef struct {
    logic                        action;
    logic [mart_pkg::ADDR_W-1:0] addr;
    logic [mart_pkg::LEN_W-1:0]  length;
    logic [mart_pkg::FLAG_W-1:0] flags;
    logic [mart_pkg::OFFS_W-1:0] offs;
    logic [mart_pkg::SIZE_W-1:0] fsize;
  } area_req_t;

  typedef struct {
    logic                        found;
    logic                        full;
    logic [IDX_W-1:0]            idx;
    logic [mart_pkg::ADDR_W-1:0] area_start;
    logic [mart_pkg::END_W-1:0]  area_end;
    logic [mart_pkg::FLAG_W-1:0] flags;
    logic [mart_pkg::OFFS_W-1:0] offs;
    logic [mart_pkg::SIZE_W-1:0] fsize;
  } area_resp_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_tvalid = 1'b0;
  logic                       in_tready;
  logic [mart_pkg::IN_DW-1:0] in_tdata = '0;
  logic                       in_tuser = 1'b0;
  logic                       out_tvalid;
  logic                       out_tready = 1'b0;
  logic [OUT_DW-1:0]          out_tdata;
  logic [1:0]                 out_tuser;

  // shadow of the table
  mart_pkg::area_t area_tab[MAX_AREAS];
  int unsigned     areas_held = 0;
  area_resp_t      pending_results[$];

  int send_idle_pct = 0;
  int stall_pct = 0;
  int fails = 0;
  int cycles = 0;
  int n_inserts = 0, n_refused = 0, n_hits = 0, n_misses = 0;

  memory_area_range_table #(.MAX_AREAS(MAX_AREAS)) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               pending_results.size());
      $display("** memory_area_range_table: FAILED **");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  function automatic area_resp_t predict_table_step(area_req_t r);
    area_resp_t      res;
    mart_pkg::area_t a;
    res = '{default: '0};
    if (r.action == mart_pkg::ACT_INSERT) begin
      if (areas_held >= MAX_AREAS) begin
        res.full = 1'b1;
        n_refused++;
        return res;
      end
      a.start_addr = r.addr;
      a.end_addr   = {1'b0, r.addr} + {1'b0, r.length};
      a.flags      = r.flags | mart_pkg::VALID_FLAG;
      a.offset     = r.offs;
      a.fsize      = r.fsize;
      area_tab[areas_held] = a;
      res.found      = 1'b1;
      res.idx        = areas_held[IDX_W-1:0];
      res.area_start = a.start_addr;
      res.area_end   = a.end_addr;
      res.flags      = a.flags;
      res.offs       = a.offset;
      res.fsize      = a.fsize;
      areas_held++;
      n_inserts++;
      return res;
    end
    for (int i = 0; i < areas_held; i++) begin
      a = area_tab[i];
      if ({1'b0, r.addr} >= {1'b0, a.start_addr} && {1'b0, r.addr} < a.end_addr) begin
        res.found      = 1'b1;
        res.idx        = i[IDX_W-1:0];
        res.area_start = a.start_addr;
        res.area_end   = a.end_addr;
        res.flags      = a.flags;
        res.offs       = a.offset;
        res.fsize      = a.fsize;
        n_hits++;
        return res;
      end
    end
    n_misses++;
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] exp);
    fails++;
    if (fails <= 40) begin
      $display("mismatch at cycle %0d: %s got 0x%0h expected 0x%0h", cycles, what, got, exp);
    end
  endtask

  // result checker
  always @(posedge clk) begin
    area_resp_t got, exp;
    if (rst_n && out_tvalid && out_tready) begin
      {got.fsize, got.offs, got.flags, got.area_end, got.area_start, got.idx} =
        out_tdata[IDX_W+mart_pkg::AREA_W-1:0];
      {got.full, got.found} = out_tuser;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected item", 64'({got.full, got.found}), 64'd0);
      end else begin
        exp = pending_results.pop_front();
        if (got.found !== exp.found)
          report_mismatch("found", 64'(got.found), 64'(exp.found));
        if (got.full !== exp.full)
          report_mismatch("full_res", 64'(got.full), 64'(exp.full));
        if (got.idx !== exp.idx)
          report_mismatch("entry_index", 64'(got.idx), 64'(exp.idx));
        if (got.area_start !== exp.area_start)
          report_mismatch("area_start", 64'(got.area_start), 64'(exp.area_start));
        if (got.area_end !== exp.area_end)
          report_mismatch("area_end", 64'(got.area_end), 64'(exp.area_end));
        if (got.flags !== exp.flags)
          report_mismatch("area_flags_out", 64'(got.flags), 64'(exp.flags));
        if (got.offs !== exp.offs)
          report_mismatch("offset_out", 64'(got.offs), 64'(exp.offs));
        if (got.fsize !== exp.fsize)
          report_mismatch("size_out", 64'(got.fsize), 64'(exp.fsize));
      end
    end
  end

  // called at a falling edge, returns at a falling edge
  task automatic send_item(area_req_t r);
    in_tvalid <= 1'b1;
    in_tuser  <= r.action;
    in_tdata  <= {2'b00, r.fsize, r.offs, r.flags, r.length, r.addr};
    do @(posedge clk); while (!in_tready);
    pending_results.push_back(predict_table_step(r));
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
  endtask

  task automatic insert_area(logic [mart_pkg::ADDR_W-1:0] addr,
                             logic [mart_pkg::LEN_W-1:0] length,
                             logic [mart_pkg::FLAG_W-1:0] flags,
                             logic [mart_pkg::OFFS_W-1:0] offs,
                             logic [mart_pkg::SIZE_W-1:0] fsize);
    area_req_t r;
    r = '{mart_pkg::ACT_INSERT, addr, length, flags, offs, fsize};
    send_item(r);
  endtask

  task automatic lookup_addr(logic [mart_pkg::ADDR_W-1:0] addr);
    area_req_t r;
    r = '{mart_pkg::ACT_LOOKUP, addr, '0, '0, '0, '0};
    send_item(r);
  endtask

  function automatic logic [mart_pkg::ADDR_W-1:0] rand_addr();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[mart_pkg::ADDR_W-1:0];
  endfunction

  // an address on or near the edges of a stored area, or within one (random if none is held)
  function automatic logic [mart_pkg::ADDR_W-1:0] near_area_addr();
    mart_pkg::area_t a;
    logic [63:0]     span;
    logic [63:0]     w;
    if (areas_held == 0) return rand_addr();
    a = area_tab[$urandom_range(areas_held - 1)];
    span = 64'(a.end_addr) - 64'(a.start_addr);
    case ($urandom_range(4))
      0: w = 64'(a.start_addr) - 64'd1;
      1: w = 64'(a.start_addr);
      2: w = 64'(a.end_addr) - 64'd1;
      3: w = 64'(a.end_addr);
      default: w = (span == 0) ? 64'(a.start_addr)
                               : 64'(a.start_addr) + ({$urandom, $urandom} % span);
    endcase
    return w[mart_pkg::ADDR_W-1:0];
  endfunction

  function automatic area_req_t rand_insert();
    area_req_t r;
    r.action = mart_pkg::ACT_INSERT;
    r.addr   = ($urandom_range(1) == 0) ? rand_addr() : near_area_addr();
    case ($urandom_range(9))
      0:       r.length = '0;
      1, 2, 3: r.length = rand_addr();
      default: r.length = mart_pkg::LEN_W'($urandom_range(1, 65536));
    endcase
    r.flags = mart_pkg::FLAG_W'($urandom);
    r.offs  = mart_pkg::OFFS_W'($urandom);
    r.fsize = mart_pkg::SIZE_W'($urandom);
    return r;
  endfunction

  task automatic test_empty_table();
    lookup_addr('0);
    lookup_addr('1);
  endtask

  task automatic test_area_edges();
    insert_area(39'h1000, 39'h1000, 8'h00, 32'h0, 32'h0);
    // overlaps the first area, which keeps priority
    insert_area(39'h1800, 39'h1000, 8'hfe, 32'h1234_5678, 32'h0000_0100);
    insert_area('1, '1, 8'hff, '1, '1);
    // zero length, never hit
    insert_area(39'h5000, 39'h0, 8'h80, 32'haaaa_5555, 32'h5555_aaaa);
    insert_area(39'h0, 39'h1, 8'h01, 32'h1, 32'h1);
    insert_area(39'h4fff, 39'h2, 8'h7e, 32'h8000_0000, 32'h8000_0000);
    lookup_addr(39'h0);
    lookup_addr(39'h1);
    lookup_addr(39'hfff);
    lookup_addr(39'h1000);
    lookup_addr(39'h1800);
    lookup_addr(39'h1fff);
    lookup_addr(39'h2000);
    lookup_addr(39'h27ff);
    lookup_addr(39'h2800);
    lookup_addr(39'h5000);
    lookup_addr(39'h5001);
    lookup_addr('1);
    lookup_addr(39'h7f_ffff_fffe);
  endtask

  task automatic test_full_table();
    while (areas_held < MAX_AREAS) send_item(rand_insert());
    insert_area('1, '1, 8'hff, '1, '1);
    insert_area('0, '0, 8'h00, '0, '0);
    lookup_addr(near_area_addr());
  endtask

  task automatic test_random_traffic(int n, int idle_pct, int stall);
    int roll;
    send_idle_pct = idle_pct;
    stall_pct = stall;
    for (int k = 0; k < n; k++) begin
      roll = $urandom_range(99);
      if (areas_held < MAX_AREAS && roll < 20) begin
        send_item(rand_insert());
      end else if (roll < 32) begin
        send_item(rand_insert());
      end else if (roll < 80) begin
        lookup_addr(near_area_addr());
      end else begin
        lookup_addr(rand_addr());
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_empty_table();
    test_area_edges();
    test_random_traffic(PHASE_ITEMS, 0, 0);
    test_full_table();
    test_random_traffic(PHASE_ITEMS, 58, 0);
    test_random_traffic(PHASE_ITEMS, 0, 58);
    test_random_traffic(PHASE_ITEMS, 31, 31);
    in_tvalid <= 1'b0;
    stall_pct = 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d inserts, %0d refused on a full table, %0d lookup hits, %0d misses",
             n_inserts, n_refused, n_hits, n_misses);
    $display("under four idle and stall mixes, %0d mismatches", fails);
    if (fails == 0) begin
      $display("** memory_area_range_table: PASSED **");
    end else begin
      $display("** memory_area_range_table: FAILED **");
    end
    $finish;
  end

endmodule
